[design/lifo_stack_with_search_unit_assert.svh]
// Assertion macros shared by the LIFO stack with search unit.
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSSU_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lssu_pkg.sv]
// Package with the command, status and state types of the LIFO stack with search unit.
package lssu_pkg;

    // Command codes carried on the cmd port.
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_SEEK = 2'd2,
        CMD_TRAV = 2'd3
    } cmd_t;

    // Status codes carried on the status port.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_NOT_FOUND = 2'd2,
        STAT_FULL      = 2'd3
    } stat_t;

    // Control states of the top level.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // Widths of the result fields.
    localparam int unsigned POS_W   = 6;
    localparam int unsigned COUNT_W = 7;
    localparam int unsigned WORD_W  = 32;

endpackage

[design/lssu_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
module lssu_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[design/lifo_stack_with_search_unit.sv]
// Top level of the LIFO stack with search unit.
// A bounded stack of DEPTH signed 32-bit words held in one synchronous RAM. A command
// transfer is taken when start is high and busy is low. For push and pop the result
// strobe follows in the next cycle and busy stays low, so a new command may be given
// every cycle. Seek and traverse walk the RAM from the top entry down, one read per
// cycle through the single read port: busy stays high while the walk visits entries,
// up to the fill count (seek stops at the topmost match). Traverse gives one result
// per entry on consecutive cycles, with last set on the bottom one. Every result is
// shown for exactly one cycle on result_valid and cannot be held off; every command
// gives at least one result, and its final result carries last. An empty stack
// answers seek, traverse and pop with a single empty status.
module lifo_stack_with_search_unit #(
    parameter int unsigned DEPTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    output logic                busy,
    output logic                result_valid,
    output logic [1:0]          status,
    output logic signed [31:0]  item_value,
    output logic [5:0]          item_position,
    output logic [6:0]          entry_count,
    output logic                last
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned FW = $clog2(DEPTH + 1);

    // Control and walk registers.
    lssu_pkg::state_t            state_reg, state_next;
    logic [FW-1:0]               fill_reg, fill_next;
    lssu_pkg::cmd_t              op_reg, op_next;
    logic [lssu_pkg::WORD_W-1:0] key_reg, key_next;
    logic [AW-1:0]               data_idx_reg, data_idx_next;

    // Result registers.
    logic                        rvalid_reg, rvalid_next;
    lssu_pkg::stat_t             status_reg, status_next;
    logic [lssu_pkg::WORD_W-1:0] ival_reg, ival_next;
    logic [lssu_pkg::POS_W-1:0]  ipos_reg, ipos_next;
    logic [lssu_pkg::COUNT_W-1:0] count_reg, count_next;
    logic                        last_reg, last_next;

    // RAM port signals.
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [AW-1:0]               ram_raddr;
    logic [lssu_pkg::WORD_W-1:0] ram_rdata;

    logic                        accept;
    lssu_pkg::cmd_t              cmd_in;
    logic                        is_full;
    logic                        is_empty;
    logic [AW-1:0]               top_addr;
    logic                        match;
    logic                        walk_done;

    assign accept    = start && (state_reg == lssu_pkg::ST_IDLE);
    assign cmd_in    = lssu_pkg::cmd_t'(cmd);
    assign is_full   = (fill_reg >= FW'(DEPTH));
    assign is_empty  = (fill_reg == '0);
    assign top_addr  = AW'(fill_reg - FW'(1));
    assign ram_waddr = AW'(fill_reg);
    assign match     = (ram_rdata == key_reg);
    assign walk_done = ((op_reg == lssu_pkg::CMD_SEEK) && match) || (data_idx_reg == '0);

    lssu_ram #(
        .WIDTH (lssu_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lssu_pkg::ST_IDLE:
            begin
                if (accept && !is_empty &&
                    ((cmd_in == lssu_pkg::CMD_SEEK) || (cmd_in == lssu_pkg::CMD_TRAV)))
                begin
                    state_next = lssu_pkg::ST_WALK;
                end
            end
            lssu_pkg::ST_WALK:
            begin
                if (walk_done)
                begin
                    state_next = lssu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lssu_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, RAM control and result values.
    always_comb
    begin
        fill_next     = fill_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        data_idx_next = data_idx_reg;
        rvalid_next   = 1'b0;
        status_next   = lssu_pkg::STAT_OK;
        ival_next     = '0;
        ipos_next     = '0;
        last_next     = 1'b1;
        ram_we        = 1'b0;
        ram_raddr     = AW'(data_idx_reg - AW'(1));

        unique case (state_reg)
            lssu_pkg::ST_IDLE:
            begin
                // The first walk read goes to the top entry in the accept cycle.
                ram_raddr = top_addr;
                if (accept)
                begin
                    unique case (cmd_in)
                        lssu_pkg::CMD_PUSH:
                        begin
                            rvalid_next = 1'b1;
                            if (is_full)
                            begin
                                status_next = lssu_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        lssu_pkg::CMD_POP:
                        begin
                            rvalid_next = 1'b1;
                            if (is_empty)
                            begin
                                status_next = lssu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - FW'(1);
                            end
                        end
                        lssu_pkg::CMD_SEEK, lssu_pkg::CMD_TRAV:
                        begin
                            if (is_empty)
                            begin
                                rvalid_next = 1'b1;
                                status_next = lssu_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                op_next       = cmd_in;
                                key_next      = value;
                                data_idx_next = top_addr;
                            end
                        end
                        default:
                        begin
                            rvalid_next = 1'b0;
                        end
                    endcase
                end
            end
            lssu_pkg::ST_WALK:
            begin
                // Read data for data_idx_reg is here; the read of the entry below is issued.
                data_idx_next = AW'(data_idx_reg - AW'(1));
                priority if (op_reg == lssu_pkg::CMD_SEEK)
                begin
                    if (match)
                    begin
                        rvalid_next = 1'b1;
                        ipos_next   = lssu_pkg::POS_W'(data_idx_reg);
                    end
                    else if (data_idx_reg == '0)
                    begin
                        rvalid_next = 1'b1;
                        status_next = lssu_pkg::STAT_NOT_FOUND;
                    end
                end
                else
                begin
                    rvalid_next = 1'b1;
                    ival_next   = ram_rdata;
                    last_next   = (data_idx_reg == '0);
                end
            end
            default:
            begin
                rvalid_next = 1'b0;
            end
        endcase

        count_next = lssu_pkg::COUNT_W'(fill_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= lssu_pkg::ST_IDLE;
            fill_reg   <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            rvalid_reg <= rvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        data_idx_reg <= data_idx_next;
        status_reg   <= status_next;
        ival_reg     <= ival_next;
        ipos_reg     <= ipos_next;
        count_reg    <= count_next;
        last_reg     <= last_next;
    end

    assign busy          = (state_reg != lssu_pkg::ST_IDLE);
    assign result_valid  = rvalid_reg;
    assign status        = status_reg;
    assign item_value    = ival_reg;
    assign item_position = ipos_reg;
    assign entry_count   = count_reg;
    assign last          = last_reg;

    // Checks on the control logic.
    `include "lifo_stack_with_search_unit_assert.svh"

    `LSSU_ASSERT_SAME(a_fill_bound, 1'b1, fill_reg <= FW'(DEPTH), "fill count above depth")
    `LSSU_ASSERT_NEXT(a_fill_hold_walk, state_reg == lssu_pkg::ST_WALK, $stable(fill_reg), "fill count moved during a walk")
    `LSSU_ASSERT_NEXT(a_quick_result, accept && ((cmd_in == lssu_pkg::CMD_PUSH) || (cmd_in == lssu_pkg::CMD_POP)), rvalid_reg && last_reg, "push or pop gave no final result")
    `LSSU_ASSERT_SAME(a_last_idle, rvalid_reg && last_reg, state_reg == lssu_pkg::ST_IDLE, "final result while still walking")
    `LSSU_ASSERT_SAME(a_midwalk_busy, rvalid_reg && !last_reg, state_reg == lssu_pkg::ST_WALK, "partial result outside a walk")

endmodule

[test/lssu_result_checker.sv]
// Result checker for the LIFO stack with search unit: predicts replies per command and compares.
`timescale 1ns / 100ps
module lssu_result_checker
    import lssu_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] value,
    input  logic               result_valid,
    input  logic [1:0]         status,
    input  logic signed [31:0] item_value,
    input  logic [5:0]         item_position,
    input  logic [6:0]         entry_count,
    input  logic               last,
    output int                 fail_count,
    output int                 pending,
    output int                 replies_checked,
    output int                 full_replies,
    output int                 match_replies
);

    // One reply of the stack, as the block should present it.
    typedef struct {
        stat_t              status;
        logic signed [31:0] word;
        logic [5:0]         position;
        logic [6:0]         count;
        logic               last;
    } reply_t;

    reply_t             awaited_replies[$];
    reply_t             oldest;
    logic signed [31:0] shadow_words[DEPTH];
    int                 shadow_fill;

    // Queue one reply; the entry count is the fill level after the command.
    function automatic void queue_reply(stat_t s, logic signed [31:0] w, logic [5:0] p,
                                        logic l);
        reply_t r;
        r.status   = s;
        r.word     = w;
        r.position = p;
        r.count    = 7'(shadow_fill);
        r.last     = l;
        awaited_replies.push_back(r);
    endfunction

    // Apply one command to the shadow stack and queue the replies it causes.
    function automatic void predict_replies(cmd_t op, logic signed [31:0] v);
        int  i;
        bit  hit;
        case (op)
            CMD_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                begin
                    queue_reply(STAT_FULL, '0, '0, 1'b1);
                    full_replies++;
                end
                else
                begin
                    shadow_words[shadow_fill] = v;
                    shadow_fill++;
                    queue_reply(STAT_OK, '0, '0, 1'b1);
                end
            end
            CMD_POP:
            begin
                if (shadow_fill == 0)
                    queue_reply(STAT_EMPTY, '0, '0, 1'b1);
                else
                begin
                    shadow_fill--;
                    queue_reply(STAT_OK, '0, '0, 1'b1);
                end
            end
            CMD_SEEK:
            begin
                if (shadow_fill == 0)
                    queue_reply(STAT_EMPTY, '0, '0, 1'b1);
                else
                begin
                    // The topmost equal entry wins.
                    hit = 1'b0;
                    for (i = shadow_fill - 1; i >= 0 && !hit; i--)
                    begin
                        if (shadow_words[i] == v)
                        begin
                            queue_reply(STAT_OK, '0, 6'(i), 1'b1);
                            match_replies++;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                        queue_reply(STAT_NOT_FOUND, '0, '0, 1'b1);
                end
            end
            default:
            begin
                if (shadow_fill == 0)
                    queue_reply(STAT_EMPTY, '0, '0, 1'b1);
                else
                begin
                    // Walk from top to bottom, flagging the bottom entry.
                    for (i = shadow_fill - 1; i >= 0; i--)
                        queue_reply(STAT_OK, shadow_words[i], '0, i == 0);
                end
            end
        endcase
    endfunction

    // Compare results leaving the block first, then take in the new command transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_replies.delete();
            shadow_fill     = 0;
            fail_count      = 0;
            pending         = 0;
            replies_checked = 0;
            full_replies    = 0;
            match_replies   = 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $error("result transfer with no reply awaited");
                    fail_count++;
                end
                else
                begin
                    oldest = awaited_replies.pop_front();
                    replies_checked++;
                    if (status !== oldest.status)
                    begin
                        $error("status: expected %0d, actual %0d", oldest.status, status);
                        fail_count++;
                    end
                    if (item_value !== oldest.word)
                    begin
                        $error("item_value: expected %0d, actual %0d", oldest.word, item_value);
                        fail_count++;
                    end
                    if (item_position !== oldest.position)
                    begin
                        $error("item_position: expected %0d, actual %0d", oldest.position,
                               item_position);
                        fail_count++;
                    end
                    if (entry_count !== oldest.count)
                    begin
                        $error("entry_count: expected %0d, actual %0d", oldest.count,
                               entry_count);
                        fail_count++;
                    end
                    if (last !== oldest.last)
                    begin
                        $error("last: expected %0d, actual %0d", oldest.last, last);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
                predict_replies(cmd_t'(cmd), value);
            pending = awaited_replies.size();
        end
    end

endmodule

[test/tb_lifo_stack_with_search_unit.sv]
// Testbench top for the LIFO stack with search unit: stimulus, run limit and verdict.
`timescale 1ns / 100ps
module tb_lifo_stack_with_search_unit;
    import lssu_pkg::*;

    localparam int DEPTH        = 32;
    localparam int RANDOM_ITEMS = 310;
    localparam int RUN_LIMIT    = 400000;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic [1:0]         cmd;
    logic signed [31:0] value;
    logic               busy;
    logic               result_valid;
    logic [1:0]         status;
    logic signed [31:0] item_value;
    logic [5:0]         item_position;
    logic [6:0]         entry_count;
    logic               last;

    int fail_count;
    int pending;
    int replies_checked;
    int full_replies;
    int match_replies;
    int cycle_count = 0;
    int op_counts[4] = '{0, 0, 0, 0};

    lifo_stack_with_search_unit #(.DEPTH(DEPTH)) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .cmd           (cmd),
        .value         (value),
        .busy          (busy),
        .result_valid  (result_valid),
        .status        (status),
        .item_value    (item_value),
        .item_position (item_position),
        .entry_count   (entry_count),
        .last          (last)
    );

    lssu_result_checker #(.DEPTH(DEPTH)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .cmd             (cmd),
        .value           (value),
        .result_valid    (result_valid),
        .status          (status),
        .item_value      (item_value),
        .item_position   (item_position),
        .entry_count     (entry_count),
        .last            (last),
        .fail_count      (fail_count),
        .pending         (pending),
        .replies_checked (replies_checked),
        .full_replies    (full_replies),
        .match_replies   (match_replies)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit, far above the slowest correct run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("[lifo_stack_with_search_unit] ERROR");
            $finish;
        end
    end

    // Present a command and hold it until the block takes the transfer.
    task automatic send_command(cmd_t op, logic signed [31:0] v);
        start <= 1'b1;
        cmd   <= op;
        value <= v;
        @(negedge clk);
        while (busy)
            @(negedge clk);
        @(posedge clk);
        op_counts[int'(op)]++;
    endtask

    // Idle the command side for a random stretch, mostly short.
    task automatic random_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 50)
            return;
        n = (r < 88) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off new commands until every awaited reply has come back.
    task automatic wait_drained();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Words from a small pool so seeks find duplicates, plus extremes and full-range noise.
    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2, 3, 4: return 32'(int'($urandom_range(0, 7)) - 3);
            default: return $urandom();
        endcase
    endfunction

    // Choose a command by the phase's mix: 0 grows, 1 shrinks, 2 is balanced.
    function automatic cmd_t pick_command(int mix);
        int r;
        r = $urandom_range(0, 99);
        case (mix)
            0:       return (r < 75) ? CMD_PUSH : (r < 80) ? CMD_POP :
                            (r < 92) ? CMD_SEEK : CMD_TRAV;
            1:       return (r < 10) ? CMD_PUSH : (r < 70) ? CMD_POP :
                            (r < 90) ? CMD_SEEK : CMD_TRAV;
            default: return (r < 30) ? CMD_PUSH : (r < 55) ? CMD_POP :
                            (r < 85) ? CMD_SEEK : CMD_TRAV;
        endcase
    endfunction

    initial
    begin
        int issued;
        int phase;
        int mix;
        int span;
        bit burst;

        rst_n = 1'b0;
        start = 1'b0;
        cmd   = CMD_PUSH;
        value = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-stack answers, extremes, duplicates, misses and a short walk.
        send_command(CMD_POP, 0);
        send_command(CMD_SEEK, 0);
        send_command(CMD_TRAV, -1);
        send_command(CMD_PUSH, 32'sh8000_0000);
        send_command(CMD_PUSH, 32'sh7fff_ffff);
        send_command(CMD_PUSH, 0);
        send_command(CMD_PUSH, -1);
        send_command(CMD_PUSH, 32'sh7fff_ffff);
        send_command(CMD_SEEK, 32'sh7fff_ffff);
        send_command(CMD_SEEK, 32'sh8000_0000);
        send_command(CMD_SEEK, 12345);
        send_command(CMD_TRAV, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_SEEK, 32'sh7fff_ffff);
        send_command(CMD_POP, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_POP, 0);
        send_command(CMD_POP, 0);
        wait_drained();

        // Random phases; the first one grows long enough to hit a full stack.
        issued = 0;
        phase  = 0;
        while (issued < RANDOM_ITEMS)
        begin
            mix   = (phase == 0) ? 0 : $urandom_range(0, 2);
            span  = (phase == 0) ? 60 : $urandom_range(15, 50);
            if (span > RANDOM_ITEMS - issued)
                span = RANDOM_ITEMS - issued;
            burst = ($urandom_range(0, 3) == 0);
            repeat (span)
            begin
                send_command(pick_command(mix), pick_word());
                issued++;
                if (!burst)
                    random_gap();
            end
            if (phase % 2 == 0)
                wait_drained();
            phase++;
        end

        // Let the last replies come back, then a short tail.
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Covered %0d commands: push %0d, pop %0d, seek %0d, traverse %0d.",
                 op_counts[0] + op_counts[1] + op_counts[2] + op_counts[3],
                 op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
        $display("Checked %0d results, %0d seek hits and %0d pushes onto a full stack.",
                 replies_checked, match_replies, full_replies);
        if (fail_count == 0)
            $display("[lifo_stack_with_search_unit] OK");
        else
            $display("[lifo_stack_with_search_unit] ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/lssu_pkg.sv
design/lssu_ram.sv
design/lifo_stack_with_search_unit.sv
test/lssu_result_checker.sv
test/tb_lifo_stack_with_search_unit.sv
